// ----- hdl/battery_gauge_level_tracker_macros.svh -----
// assertion macros shared by the battery gauge rtl
// no dependencies
`ifndef BATTERY_GAUGE_LEVEL_TRACKER_MACROS_SVH
`define BATTERY_GAUGE_LEVEL_TRACKER_MACROS_SVH
`define BGL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
`define BGL_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m failed");
`endif

// ----- hdl/bgl_pkg.sv -----
// package for the battery gauge level tracker
// types, constants and the climb rule table; no dependencies
package bgl_pkg;
  localparam logic [15:0] VMin   = 16'd3100;
  localparam logic [15:0] VDisL3 = 16'd3903;
  localparam logic [15:0] VDisL2 = 16'd3773;
  localparam logic [15:0] VDisL1 = 16'd3712;
  localparam logic [15:0] VDisL0 = 16'd3460;
  localparam logic [7:0]  NoneReported = 8'd255;

  typedef struct packed {
    logic        charging;
    logic [1:0]  supply_kind;
    logic [15:0] volt_mv;
    logic signed [7:0] temp_c;
    logic [15:0] current_ma;
    logic [14:0] max_current_ma;
  } in_word_t;

  typedef struct packed {
    logic [6:0] shown_percent;
    logic [2:0] band_level;
    logic       reported;
  } out_word_t;

  typedef struct packed {
    logic        by_volt;
    logic [15:0] thr;
    logic [15:0] other;
  } climb_rule_t;

  // divider request / response
  typedef struct packed {
    logic        start;
    logic [20:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [20:0] quo;
  } div_rsp_t;

  function automatic climb_rule_t rule_lookup(input logic usb, input logic [1:0] rng,
                                              input logic [1:0] lv);
    climb_rule_t r;
    r = '{1'b0, 16'd0, 16'd0};
    unique case ({usb, rng, lv})
      5'd0:  r = '{1'b0, 16'd510, 16'd0};
      5'd1:  r = '{1'b0, 16'd480, 16'd510};
      5'd2:  r = '{1'b0, 16'd320, 16'd480};
      5'd3:  r = '{1'b0, 16'd80, 16'd320};
      5'd4:  r = '{1'b1, 16'd4000, 16'd3100};
      5'd5:  r = '{1'b1, 16'd4090, 16'd4000};
      5'd6:  r = '{1'b0, 16'd510, 16'd0};
      5'd7:  r = '{1'b0, 16'd70, 16'd510};
      5'd8:  r = '{1'b1, 16'd3925, 16'd3100};
      5'd9:  r = '{1'b1, 16'd4015, 16'd3925};
      5'd10: r = '{1'b1, 16'd4175, 16'd4015};
      5'd11: r = '{1'b0, 16'd90, 16'd0};
      5'd12: r = '{1'b1, 16'd3885, 16'd3100};
      5'd13: r = '{1'b1, 16'd3975, 16'd3885};
      5'd14: r = '{1'b1, 16'd4135, 16'd3975};
      5'd15: r = '{1'b0, 16'd130, 16'd0};
      5'd16: r = '{1'b1, 16'd4090, 16'd3100};
      5'd17: r = '{1'b1, 16'd4165, 16'd4090};
      5'd18: r = '{1'b0, 16'd290, 16'd0};
      5'd19: r = '{1'b0, 16'd50, 16'd290};
      5'd20: r = '{1'b1, 16'd3910, 16'd3100};
      5'd21: r = '{1'b1, 16'd3990, 16'd3910};
      5'd22: r = '{1'b1, 16'd4140, 16'd3990};
      5'd23: r = '{1'b0, 16'd90, 16'd0};
      5'd24: r = '{1'b1, 16'd3860, 16'd3100};
      5'd25: r = '{1'b1, 16'd3940, 16'd3860};
      5'd26: r = '{1'b1, 16'd4080, 16'd3940};
      5'd27: r = '{1'b0, 16'd180, 16'd0};
      5'd28: r = '{1'b1, 16'd3830, 16'd3100};
      5'd29: r = '{1'b1, 16'd3915, 16'd3830};
      5'd30: r = '{1'b1, 16'd4050, 16'd3915};
      5'd31: r = '{1'b0, 16'd230, 16'd0};
      default: r = '{1'b0, 16'd0, 16'd0};
    endcase
    return r;
  endfunction

  function automatic logic [6:0] band_base(input logic [1:0] lv);
    logic [6:0] b;
    unique case (lv)
      2'd0: b = 7'd0;
      2'd1: b = 7'd25;
      2'd2: b = 7'd50;
      default: b = 7'd80;
    endcase
    return b;
  endfunction

  function automatic logic [4:0] band_span(input logic [1:0] lv);
    logic [4:0] s;
    unique case (lv)
      2'd0, 2'd1: s = 5'd25;
      2'd2: s = 5'd30;
      default: s = 5'd20;
    endcase
    return s;
  endfunction
endpackage

// ----- hdl/bgl_stream_if.sv -----
// valid/ready channels carrying one word of type in_word_t or out_word_t
// depends on bgl_pkg
interface bgl_in_if import bgl_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bgl_out_if import bgl_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/bgl_divider.sv -----
// restoring serial divider, one quotient bit per cycle
// depends on bgl_pkg
module bgl_divider import bgl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic [20:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [17:0] trial;
  logic [16:0] shifted;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    shifted = {rem_q[15:0], quo_q[20]};
    trial = {1'b0, shifted} - {2'b0, den_q};
    if (req_i.start) begin
      quo_d = req_i.num; rem_d = '0; den_d = req_i.den; cnt_d = 5'd21; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[17]) begin
        rem_d = trial[16:0]; quo_d = {quo_q[19:0], 1'b1};
      end else begin
        rem_d = shifted; quo_d = {quo_q[19:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
endmodule

// ----- hdl/battery_gauge_level_tracker.sv -----
// battery gauge level tracker: one sample in, one result word out
// a division holds the fsm in S_DIV until the divider raises its done flag after all 21 quotient bits
// a new sample is taken only in the idle state, after the last result word is accepted; output stalls hold the fsm
// reset: band 4, display 100, discharging mode, no item in flight
// depends on bgl_pkg, bgl_stream_if, bgl_divider and the macros header
`include "battery_gauge_level_tracker_macros.svh"
module battery_gauge_level_tracker import bgl_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  bgl_in_if.sink    in_i,
  bgl_out_if.source out_o
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_PREP = 4'b0010, S_DIV = 4'b0100, S_OUT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  in_word_t smp_q;
  logic [2:0] band_q, band_d;
  logic [6:0] cpct_q, cpct_d, dpct_q, dpct_d, disp_q, disp_d;
  logic [7:0] lrep_q, lrep_d;
  logic mode_q, mode_d, rep_q, rep_d;
  logic [6:0] base_q, base_d;
  logic sub_q, sub_d;   // result = base - quotient
  logic dis_q, dis_d;   // writes discharge percent
  logic floor_q, floor_d;
  div_req_t dreq;
  div_rsp_t drsp;

  bgl_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  climb_rule_t rl;
  logic [1:0] rng, lv2;
  logic [2:0] seed;
  logic [15:0] v, hi, lo, c;
  logic [6:0] newp;

  always_comb begin
    state_d = state_q; band_d = band_q; cpct_d = cpct_q; dpct_d = dpct_q;
    disp_d = disp_q; lrep_d = lrep_q; mode_d = mode_q; rep_d = rep_q;
    base_d = base_q; sub_d = sub_q; dis_d = dis_q; floor_d = floor_q;
    dreq = '{1'b0, 21'd0, 16'd1};
    rng = 2'd0; lv2 = band_q[1:0]; seed = 3'd0; v = '0; hi = '0; lo = '0; c = '0;
    newp = '0;
    rl = rule_lookup(smp_q.supply_kind[0], 2'd0, band_q[1:0]);
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_PREP;
          if (in_i.data.charging != mode_q) begin
            lrep_d = NoneReported; mode_d = in_i.data.charging;
            if (in_i.data.charging) seed = 3'd0;
            else if (in_i.data.volt_mv > VDisL3) seed = 3'd4;
            else if (in_i.data.volt_mv > VDisL2) seed = 3'd3;
            else if (in_i.data.volt_mv > VDisL1) seed = 3'd2;
            else if (in_i.data.volt_mv > VDisL0) seed = 3'd1;
            else seed = 3'd0;
            band_d = seed;
          end
        end
      end
      S_PREP: begin
        state_d = S_OUT;   // default: no division needed
        floor_d = 1'b0;
        if (smp_q.charging) begin
          dis_d = 1'b0; sub_d = 1'b0;
          if (smp_q.temp_c < 8'sd10) rng = 2'd0;
          else if (smp_q.temp_c < 8'sd20) rng = 2'd1;
          else if (smp_q.temp_c < 8'sd30) rng = 2'd2;
          else rng = 2'd3;
          rl = rule_lookup(smp_q.supply_kind[0], rng, lv2);
          base_d = band_base(lv2);
          if (smp_q.supply_kind[1] || band_q[2]) begin
            state_d = S_OUT;
          end else if (rl.by_volt) begin
            if (smp_q.volt_mv > rl.thr) begin
              band_d = band_q + 3'd1;
              cpct_d = band_base(lv2) + 7'(band_span(lv2));
            end else begin
              v = (smp_q.volt_mv < rl.other) ? rl.other : smp_q.volt_mv;
              dreq = '{1'b1, 21'(band_span(lv2)) * 21'(v - rl.other), rl.thr - rl.other};
              state_d = S_DIV;
            end
          end else begin
            lo = rl.thr;
            hi = (rl.other != 16'd0) ? rl.other : {1'b0, smp_q.max_current_ma};
            if (smp_q.current_ma < lo) begin
              band_d = band_q + 3'd1;
              cpct_d = band_base(lv2) + 7'(band_span(lv2));
            end else if (hi <= lo) begin
              cpct_d = band_base(lv2);
            end else begin
              c = (smp_q.current_ma > hi) ? hi : smp_q.current_ma;
              dreq = '{1'b1, 21'(band_span(lv2)) * 21'(hi - c), hi - lo};
              state_d = S_DIV;
            end
          end
        end else begin
          dis_d = 1'b1; sub_d = 1'b1;
          unique case (band_q)
            3'd4: begin
              if (smp_q.volt_mv < VDisL3) begin
                band_d = 3'd3; dpct_d = 7'd100;
              end else if (dpct_q < 7'd80) dpct_d = 7'd100;
            end
            3'd3: begin
              if (smp_q.volt_mv < VDisL2) begin
                band_d = 3'd2; dpct_d = 7'd80;
              end else begin
                v = (smp_q.volt_mv > VDisL3) ? VDisL3 : smp_q.volt_mv;
                base_d = 7'd100;
                dreq = '{1'b1, 21'd20 * 21'(VDisL3 - v), VDisL3 - VDisL2};
                state_d = S_DIV;
              end
            end
            3'd2: begin
              if (smp_q.volt_mv < VDisL1) begin
                band_d = 3'd1; dpct_d = 7'd50;
              end else begin
                v = (smp_q.volt_mv > VDisL2) ? VDisL2 : smp_q.volt_mv;
                base_d = 7'd80;
                dreq = '{1'b1, 21'd30 * 21'(VDisL2 - v), VDisL2 - VDisL1};
                state_d = S_DIV;
              end
            end
            3'd1: begin
              if (smp_q.volt_mv < VDisL0) begin
                band_d = 3'd0; dpct_d = 7'd25;
              end else begin
                v = (smp_q.volt_mv > VDisL1) ? VDisL1 : smp_q.volt_mv;
                base_d = 7'd50;
                dreq = '{1'b1, 21'd25 * 21'(VDisL1 - v), VDisL1 - VDisL0};
                state_d = S_DIV;
              end
            end
            default: begin
              v = (smp_q.volt_mv > VDisL0) ? VDisL0 : smp_q.volt_mv;
              base_d = 7'd25; floor_d = 1'b1;
              dreq = '{1'b1, 21'd25 * 21'(VDisL0 - v), VDisL0 - VMin};
              state_d = S_DIV;
            end
          endcase
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          state_d = S_OUT;
          if (sub_q) begin
            if (floor_q && drsp.quo >= 21'd25) newp = 7'd0;
            else newp = base_q - drsp.quo[6:0];
          end else newp = base_q + drsp.quo[6:0];
          if (dis_q) dpct_d = newp; else cpct_d = newp;
        end
      end
      S_OUT: begin
        if (out_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // report update happens when entering S_OUT
  logic enter_out;
  assign enter_out = (state_d == S_OUT) && (state_q != S_OUT);
  logic [6:0] cp_n, dp_n;
  always_comb begin
    cp_n = cpct_d; dp_n = dpct_d;
  end

  logic [7:0] lrep_f;
  logic [6:0] disp_f;
  logic rep_f;
  always_comb begin
    lrep_f = lrep_d; disp_f = disp_d; rep_f = rep_d;
    if (enter_out) begin
      rep_f = 1'b0;
      if (smp_q.charging) begin
        if (!smp_q.supply_kind[1] && ({1'b0, cp_n} != lrep_d)) begin
          lrep_f = {1'b0, cp_n}; rep_f = 1'b1;
          if (cp_n > disp_q) disp_f = cp_n;
        end
      end else if ({1'b0, dp_n} != lrep_d) begin
        lrep_f = {1'b0, dp_n}; rep_f = 1'b1;
        if (dp_n < disp_q) disp_f = dp_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; band_q <= 3'd4; cpct_q <= 7'd100; dpct_q <= 7'd0;
      lrep_q <= 8'd0; disp_q <= 7'd100; mode_q <= 1'b0; rep_q <= 1'b0;
      sub_q <= 1'b0; dis_q <= 1'b0; floor_q <= 1'b0; base_q <= '0;
    end else begin
      state_q <= state_d; band_q <= band_d; cpct_q <= cpct_d; dpct_q <= dpct_d;
      lrep_q <= lrep_f; disp_q <= disp_f; mode_q <= mode_d; rep_q <= rep_f;
      sub_q <= sub_d; dis_q <= dis_d; floor_q <= floor_d; base_q <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) smp_q <= in_i.data;
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = (state_q == S_OUT);
  assign out_o.data = '{disp_q, band_q, rep_q};

  `BGL_ASSERT(a_band_range, clk_i, rst_ni, band_q <= 3'd4)
  `BGL_ASSERT(a_disp_range, clk_i, rst_ni, disp_q <= 7'd100)
  `BGL_ASSERT(a_div_done_in_div, clk_i, rst_ni, drsp.done |-> state_q == S_DIV)
  `BGL_ASSERT(a_onehot, clk_i, rst_ni, $onehot(state_q))
  `BGL_ASSERT_RST(a_reset_idle, clk_i, !rst_ni |=> state_q == S_IDLE)
endmodule

// ----- verif/battery_gauge_level_tracker_checker.sv -----
// checker for the battery gauge level tracker: watches both channels,
// predicts each result word from the accepted samples and compares
// depends on bgl_pkg and bgl_stream_if
`timescale 1ns / 100ps
module battery_gauge_level_tracker_checker import bgl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bgl_in_if          in_i,
  bgl_out_if         out_o,
  output int         fail_count_o,
  output int         pending_o,
  output int         reports_o
);
  logic [2:0] band_q;
  logic [6:0] chg_pct_q;
  logic [6:0] dis_pct_q;
  logic [7:0] last_rep_q;
  logic [6:0] disp_pct_q;
  logic       mode_q;
  out_word_t  gauge_q[$];

  function automatic logic [6:0] climb_base(input logic [1:0] lv);
    case (lv)
      2'd0: return 7'd0;
      2'd1: return 7'd25;
      2'd2: return 7'd50;
      default: return 7'd80;
    endcase
  endfunction

  function automatic int unsigned climb_span(input logic [1:0] lv);
    case (lv)
      2'd2: return 30;
      2'd3: return 20;
      default: return 25;
    endcase
  endfunction

  // by_volt, threshold, other
  function automatic void climb_rule(input logic usb, input logic [1:0] rng,
                                     input logic [1:0] lv, output bit byv,
                                     output int unsigned thr, output int unsigned oth);
    int unsigned tbl [32][3] = '{
      '{0, 510, 0}, '{0, 480, 510}, '{0, 320, 480}, '{0, 80, 320},
      '{1, 4000, 3100}, '{1, 4090, 4000}, '{0, 510, 0}, '{0, 70, 510},
      '{1, 3925, 3100}, '{1, 4015, 3925}, '{1, 4175, 4015}, '{0, 90, 0},
      '{1, 3885, 3100}, '{1, 3975, 3885}, '{1, 4135, 3975}, '{0, 130, 0},
      '{1, 4090, 3100}, '{1, 4165, 4090}, '{0, 290, 0}, '{0, 50, 290},
      '{1, 3910, 3100}, '{1, 3990, 3910}, '{1, 4140, 3990}, '{0, 90, 0},
      '{1, 3860, 3100}, '{1, 3940, 3860}, '{1, 4080, 3940}, '{0, 180, 0},
      '{1, 3830, 3100}, '{1, 3915, 3830}, '{1, 4050, 3915}, '{0, 230, 0}};
    int idx;
    idx = int'({usb, rng, lv});
    byv = tbl[idx][0][0];
    thr = tbl[idx][1];
    oth = tbl[idx][2];
  endfunction

  function automatic void charge_climb(input in_word_t w);
    logic [1:0] rng;
    logic [1:0] lv;
    bit byv;
    int unsigned thr, oth, base, span, hi, lo, v, c;
    if (band_q > 3'd3) return;
    lv = band_q[1:0];
    if (w.temp_c < 10) rng = 2'd0;
    else if (w.temp_c < 20) rng = 2'd1;
    else if (w.temp_c < 30) rng = 2'd2;
    else rng = 2'd3;
    climb_rule(w.supply_kind[0], rng, lv, byv, thr, oth);
    base = climb_base(lv);
    span = climb_span(lv);
    if (byv) begin
      hi = thr;
      lo = oth;
      if (w.volt_mv > hi) begin
        band_q = band_q + 3'd1;
        chg_pct_q = 7'(base + span);
        return;
      end
      v = (w.volt_mv < lo) ? lo : w.volt_mv;
      chg_pct_q = 7'(base + span * (v - lo) / (hi - lo));
    end else begin
      lo = thr;
      hi = (oth != 0) ? oth : w.max_current_ma;
      if (w.current_ma < lo) begin
        band_q = band_q + 3'd1;
        chg_pct_q = 7'(base + span);
        return;
      end
      if (hi <= lo) begin
        chg_pct_q = 7'(base);
        return;
      end
      c = (w.current_ma > hi) ? hi : w.current_ma;
      chg_pct_q = 7'(base + span * (hi - c) / (hi - lo));
    end
  endfunction

  function automatic void discharge_fall(input logic [15:0] volt);
    int unsigned v, drop;
    case (band_q)
      3'd4: begin
        if (volt < VDisL3) begin
          band_q = 3'd3;
          dis_pct_q = 7'd100;
        end else if (dis_pct_q < 7'd80) begin
          dis_pct_q = 7'd100;
        end
      end
      3'd3: begin
        if (volt < VDisL2) begin
          band_q = 3'd2;
          dis_pct_q = 7'd80;
        end else begin
          v = (volt > VDisL3) ? VDisL3 : volt;
          dis_pct_q = 7'(100 - 20 * (VDisL3 - v) / (VDisL3 - VDisL2));
        end
      end
      3'd2: begin
        if (volt < VDisL1) begin
          band_q = 3'd1;
          dis_pct_q = 7'd50;
        end else begin
          v = (volt > VDisL2) ? VDisL2 : volt;
          dis_pct_q = 7'(80 - 30 * (VDisL2 - v) / (VDisL2 - VDisL1));
        end
      end
      3'd1: begin
        if (volt < VDisL0) begin
          band_q = 3'd0;
          dis_pct_q = 7'd25;
        end else begin
          v = (volt > VDisL1) ? VDisL1 : volt;
          dis_pct_q = 7'(50 - 25 * (VDisL1 - v) / (VDisL1 - VDisL0));
        end
      end
      default: begin
        v = (volt > VDisL0) ? VDisL0 : volt;
        drop = 25 * (VDisL0 - v) / (VDisL0 - VMin);
        dis_pct_q = (drop >= 25) ? 7'd0 : 7'(25 - drop);
      end
    endcase
  endfunction

  function automatic out_word_t gauge_step(input in_word_t w);
    out_word_t r;
    logic rep;
    rep = 1'b0;
    if (mode_q != w.charging) begin
      last_rep_q = NoneReported;
      mode_q = w.charging;
      if (w.charging) band_q = 3'd0;
      else if (w.volt_mv > VDisL3) band_q = 3'd4;
      else if (w.volt_mv > VDisL2) band_q = 3'd3;
      else if (w.volt_mv > VDisL1) band_q = 3'd2;
      else if (w.volt_mv > VDisL0) band_q = 3'd1;
      else band_q = 3'd0;
    end
    if (w.charging) begin
      if (w.supply_kind <= 2'd1) begin
        charge_climb(w);
        if ({1'b0, chg_pct_q} != last_rep_q) begin
          last_rep_q = {1'b0, chg_pct_q};
          if (chg_pct_q > disp_pct_q) disp_pct_q = chg_pct_q;
          rep = 1'b1;
        end
      end
    end else begin
      discharge_fall(w.volt_mv);
      if ({1'b0, dis_pct_q} != last_rep_q) begin
        last_rep_q = {1'b0, dis_pct_q};
        if (dis_pct_q < disp_pct_q) disp_pct_q = dis_pct_q;
        rep = 1'b1;
      end
    end
    r.shown_percent = disp_pct_q;
    r.band_level = band_q;
    r.reported = rep;
    return r;
  endfunction

  assign pending_o = gauge_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      band_q = 3'd4;
      chg_pct_q = 7'd100;
      dis_pct_q = 7'd0;
      last_rep_q = 8'd0;
      disp_pct_q = 7'd100;
      mode_q = 1'b0;
      fail_count_o <= 0;
      reports_o <= 0;
      gauge_q.delete();
    end else begin
      if (out_o.valid && out_o.ready) begin
        if (gauge_q.size() == 0) begin
          $error("unexpected result word %h", out_o.data);
          errs = errs + 1;
        end else begin
          e = gauge_q.pop_front();
          if (e.reported) reports_o <= reports_o + 1;
          if (e.shown_percent !== out_o.data.shown_percent) begin
            $error("shown_percent exp %0d got %0d", e.shown_percent, out_o.data.shown_percent);
            errs = errs + 1;
          end
          if (e.band_level !== out_o.data.band_level) begin
            $error("band_level exp %0d got %0d", e.band_level, out_o.data.band_level);
            errs = errs + 1;
          end
          if (e.reported !== out_o.data.reported) begin
            $error("reported exp %0d got %0d", e.reported, out_o.data.reported);
            errs = errs + 1;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      if (in_i.valid && in_i.ready) gauge_q.push_back(gauge_step(in_i.data));
    end
  end
endmodule

// ----- verif/testbench.sv -----
// top of the battery gauge level tracker bench: clock, reset, sample stimulus
// depends on bgl_pkg, bgl_stream_if, the rtl and the checker
`timescale 1ns / 100ps
module testbench import bgl_pkg::*;;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, reports;
  int   src_idle, snk_idle;
  longint cycles = 0;

  bgl_in_if  in_if ();
  bgl_out_if out_if ();

  battery_gauge_level_tracker u_top (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_i (in_if.sink), .out_o (out_if.source)
  );

  battery_gauge_level_tracker_checker u_chk (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_i (in_if), .out_o (out_if),
    .fail_count_o (fail_count), .pending_o (pending), .reports_o (reports)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    src_idle = 0;
    snk_idle = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    out_if.ready <= ($urandom_range(99) >= snk_idle);
    if (cycles > 400000) begin
      $display("battery_gauge_level_tracker: mismatch");
      $finish;
    end
  end

  task automatic send_sample(input in_word_t w);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
  endtask

  function automatic in_word_t sample_of(input logic chg, input logic [1:0] sup,
                                         input int volt, input int temp,
                                         input int cur, input int maxc);
    in_word_t w;
    w.charging = chg;
    w.supply_kind = sup;
    w.volt_mv = 16'(volt);
    w.temp_c = 8'(temp);
    w.current_ma = 16'(cur);
    w.max_current_ma = 15'(maxc);
    return w;
  endfunction

  function automatic in_word_t random_sample(input logic chg);
    in_word_t w;
    int temps [4] = '{5, 15, 25, 40};
    w = in_word_t'(58'({$urandom, $urandom}));
    w.charging = chg;
    case ($urandom_range(9))
      0: ;
      1, 2: w.volt_mv = 16'($urandom_range(3000, 3700));
      default: w.volt_mv = 16'($urandom_range(3400, 4250));
    endcase
    if ($urandom_range(9) < 8) begin
      w.supply_kind = 2'($urandom_range(1));
      w.temp_c = 8'(temps[$urandom_range(3)] + $urandom_range(4));
      w.current_ma = 16'($urandom_range(0, 700));
      w.max_current_ma = 15'($urandom_range(0, 900));
    end
    return w;
  endfunction

  task automatic phase(input int n, input int s_idle, input int r_idle);
    logic chg;
    src_idle = s_idle;
    snk_idle = r_idle;
    chg = 1'b1;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(24) == 0) chg = ~chg;
      if (i == n / 2) drain();
      send_sample(random_sample(chg));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // discharge from full down to the floor
    send_sample(sample_of(0, 2, 65535, -128, 0, 0));
    send_sample(sample_of(0, 2, 3850, 0, 0, 0));
    send_sample(sample_of(0, 2, 3740, 0, 0, 0));
    send_sample(sample_of(0, 2, 3600, 0, 0, 0));
    send_sample(sample_of(0, 2, 3200, 0, 0, 0));
    send_sample(sample_of(0, 2, 0, 0, 0, 0));
    // charging without a charger, then climb through every temperature range
    send_sample(sample_of(1, 2, 3500, 20, 100, 600));
    send_sample(sample_of(1, 3, 3500, 20, 100, 600));
    send_sample(sample_of(1, 0, 3500, -128, 600, 0));
    send_sample(sample_of(1, 0, 3500, 0, 600, 32767));
    send_sample(sample_of(1, 0, 3500, 5, 400, 600));
    send_sample(sample_of(1, 0, 3500, 5, 10, 600));
    send_sample(sample_of(1, 0, 3500, 5, 100, 600));
    send_sample(sample_of(1, 0, 3500, 5, 10, 600));
    send_sample(sample_of(1, 0, 4200, 5, 65535, 600));
    send_sample(sample_of(1, 1, 3950, 15, 0, 0));
    send_sample(sample_of(1, 1, 4200, 15, 0, 0));
    send_sample(sample_of(1, 1, 4200, 25, 0, 0));
    send_sample(sample_of(1, 1, 4200, 127, 0, 0));
    send_sample(sample_of(1, 1, 4200, 35, 10, 0));
    send_sample(sample_of(0, 0, 3950, 35, 0, 0));
    send_sample(sample_of(0, 0, 3800, 35, 0, 0));
    phase(260, 9, 64);
    phase(260, 64, 9);
    phase(260, 0, 0);
    drain();
    repeat (60) @(posedge clk_i);
    $display("samples: 802, mode changes, all bands, both chargers, all temperature ranges");
    $display("reported levels seen: %0d", reports);
    if (fail_count == 0) begin
      $display("battery_gauge_level_tracker: match");
    end else begin
      $display("battery_gauge_level_tracker: mismatch");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/bgl_pkg.sv
hdl/bgl_stream_if.sv
hdl/bgl_divider.sv
hdl/battery_gauge_level_tracker.sv
verif/battery_gauge_level_tracker_checker.sv
verif/testbench.sv
